@@ rtl/svi_pkg.sv @@
// Shared constants, a table and types for the spherical point voxel indexer.
package svi_pkg;

   localparam int SQRT_STEPS   = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int LN_STEPS     = 16;
   localparam int CORDIC_W     = 27;
   localparam int ANGLE_W      = 23;
   localparam int HALF_PI_Q20  = 1647099;
   localparam int LN2_Q16      = 45426;
   localparam int ANGLE_SHIFT  = 22;
   localparam int LIN_SHIFT    = 16;
   localparam int LOG_SHIFT    = 20;

   localparam int ATAN_Q20 [CORDIC_STEPS] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
   };

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_INV_THETA  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INV_PHI    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_INV_DEPTH  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_CNT    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_COLUMN_CNT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_DEPTH_CNT  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_LOG_DEPTH  = 3'd6;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [15:0]        refl;
   } point_type;

endpackage

@@ rtl/svi_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module svi_isqrt (
   input  logic        clock,
   input  logic [31:0] val,
   output logic [15:0] root
);

   logic [31:0] v_ff    [svi_pkg::SQRT_STEPS];
   logic [17:0] rem_ff  [svi_pkg::SQRT_STEPS];
   logic [15:0] root_ff [svi_pkg::SQRT_STEPS];

   for (genvar k = 0; k < svi_pkg::SQRT_STEPS; k++) begin : g_stage
      logic [31:0] v_prev;
      logic [17:0] rem_prev;
      logic [15:0] root_prev;
      logic [19:0] rem_sh;
      logic [19:0] trial;
      logic [17:0] rem_in;
      logic [15:0] root_in;

      if (k == 0) begin : g_first
         assign v_prev    = val;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev, v_prev[31-2*k -: 2]};
         trial  = {2'b00, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = 18'(rem_sh - trial);
            root_in = {root_prev[14:0], 1'b1};
         end else begin
            rem_in  = rem_sh[17:0];
            root_in = {root_prev[14:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         v_ff[k]    <= v_prev;
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
      end
   end

   assign root = root_ff[svi_pkg::SQRT_STEPS-1];

endmodule

@@ rtl/svi_cordic.sv @@
// Pipelined vectoring CORDIC giving atan2(y, x) for x >= 0 in Q20 radians.
module svi_cordic (
   input  logic                                clock,
   input  logic [15:0]                         x_in,
   input  logic signed [15:0]                  y_in,
   output logic signed [svi_pkg::ANGLE_W-1:0]  angle
);

   localparam int AW = svi_pkg::CORDIC_W;
   localparam int GW = svi_pkg::ANGLE_W;

   logic signed [AW-1:0] a_ff   [svi_pkg::CORDIC_STEPS];
   logic signed [AW-1:0] b_ff   [svi_pkg::CORDIC_STEPS];
   logic signed [GW-1:0] acc_ff [svi_pkg::CORDIC_STEPS];

   logic signed [23:0] a0;
   logic signed [23:0] b0;

   assign a0 = {x_in, 8'h00};
   assign b0 = {y_in, 8'h00};

   for (genvar i = 0; i < svi_pkg::CORDIC_STEPS; i++) begin : g_iter
      logic signed [AW-1:0] a_prev;
      logic signed [AW-1:0] b_prev;
      logic signed [GW-1:0] acc_prev;
      logic signed [AW-1:0] da;
      logic signed [AW-1:0] db;
      logic signed [GW-1:0] step;

      if (i == 0) begin : g_first
         assign a_prev   = AW'(signed'({1'b0, a0[23:0]}));
         assign b_prev   = AW'(b0);
         assign acc_prev = '0;
      end else begin : g_next
         assign a_prev   = a_ff[i-1];
         assign b_prev   = b_ff[i-1];
         assign acc_prev = acc_ff[i-1];
      end

      assign da   = b_prev >>> i;
      assign db   = a_prev >>> i;
      assign step = GW'(svi_pkg::ATAN_Q20[i]);

      always_ff @(posedge clock) begin
         if (!b_prev[AW-1]) begin
            a_ff[i]   <= a_prev + da;
            b_ff[i]   <= b_prev - db;
            acc_ff[i] <= acc_prev + step;
         end else begin
            a_ff[i]   <= a_prev - da;
            b_ff[i]   <= b_prev + db;
            acc_ff[i] <= acc_prev - step;
         end
      end
   end

   assign angle = acc_ff[svi_pkg::CORDIC_STEPS-1];

endmodule

@@ rtl/spherical_point_voxel_indexer.sv @@
// Top level: lidar point to spherical voxel bin indexer, fully pipelined.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  req     | start, busy               | x_pos, y_pos, z_pos, reflectance
//  rsp     | rsp_valid (strobe)        | valid_res, row/column/depth index, x/y/z/refl
//  csr     | csr_valid, csr_ready      | csr_index, csr_data
//
// One item per clock; each result appears on the response channel once its item has
// passed the square root (16 stages) followed by the CORDIC
// (20 stages); the log path runs beside the CORDIC.
// Synchronous reset clears valid bits and loads register defaults.
// busy stays low; results are strobed for one cycle and never held.
module spherical_point_voxel_indexer #(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_DEPTHS  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [15:0]                req_x_pos,
   input  logic signed [15:0]                req_y_pos,
   input  logic signed [15:0]                req_z_pos,
   input  logic [15:0]                       req_reflectance,
   output logic                              rsp_valid,
   output logic                              rsp_valid_res,
   output logic [9:0]                        rsp_row_index,
   output logic [9:0]                        rsp_column_index,
   output logic [9:0]                        rsp_depth_index,
   output logic signed [15:0]                rsp_x_out,
   output logic signed [15:0]                rsp_y_out,
   output logic signed [15:0]                rsp_z_out,
   output logic [15:0]                       rsp_refl_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [svi_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [svi_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int LAT    = 42;
   localparam int SIDE_N = 38;
   localparam int RD_N   = 20;
   localparam int TAP19  = 15;
   localparam int ROW_CW = $clog2(MAX_ROWS + 1);
   localparam int COL_CW = $clog2(MAX_COLUMNS + 1);
   localparam int DEP_CW = $clog2(MAX_DEPTHS + 1);

   typedef struct packed {
      svi_pkg::point_type pt;
      logic               nz;
   } side_type;

   // configuration
   logic [15:0] inv_theta_ff, inv_phi_ff, inv_depth_ff;
   logic [10:0] row_cnt_ff, col_cnt_ff, dep_cnt_ff;
   logic        log_depth_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_theta_ff <= 16'd256;
         inv_phi_ff   <= 16'd256;
         inv_depth_ff <= 16'd256;
         row_cnt_ff   <= 11'd1024;
         col_cnt_ff   <= 11'd1024;
         dep_cnt_ff   <= 11'd1024;
         log_depth_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            svi_pkg::REG_INV_THETA:  inv_theta_ff <= csr_data;
            svi_pkg::REG_INV_PHI:    inv_phi_ff   <= csr_data;
            svi_pkg::REG_INV_DEPTH:  inv_depth_ff <= csr_data;
            svi_pkg::REG_ROW_CNT:    row_cnt_ff   <= csr_data[10:0];
            svi_pkg::REG_COLUMN_CNT: col_cnt_ff   <= csr_data[10:0];
            svi_pkg::REG_DEPTH_CNT:  dep_cnt_ff   <= csr_data[10:0];
            svi_pkg::REG_LOG_DEPTH:  log_depth_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // valid bits, stage 1 .. LAT
   logic [LAT:1] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-1:1], start & ~busy};
      end
   end

   // stage 1: capture
   svi_pkg::point_type pt1_ff, pt2_ff, pt3_ff;

   always_ff @(posedge clock) begin
      pt1_ff <= '{x: req_x_pos, y: req_y_pos, z: req_z_pos, refl: req_reflectance};
   end

   // stage 2: squares
   logic signed [31:0] x2_in, y2_in, z2_in;
   logic [30:0]        x2_ff, y2_ff, z2_ff;

   assign x2_in = pt1_ff.x * pt1_ff.x;
   assign y2_in = pt1_ff.y * pt1_ff.y;
   assign z2_in = pt1_ff.z * pt1_ff.z;

   always_ff @(posedge clock) begin
      x2_ff  <= x2_in[30:0];
      y2_ff  <= y2_in[30:0];
      z2_ff  <= z2_in[30:0];
      pt2_ff <= pt1_ff;
   end

   // stage 3: sums
   logic [31:0] sxy_in, s3_in;
   logic [31:0] sxy_ff, s3_ff;
   logic        nz3_ff;

   assign sxy_in = {1'b0, x2_ff} + {1'b0, y2_ff};
   assign s3_in  = sxy_in + {1'b0, z2_ff};

   always_ff @(posedge clock) begin
      sxy_ff <= sxy_in;
      s3_ff  <= s3_in;
      nz3_ff <= (sxy_in != '0);
      pt3_ff <= pt2_ff;
   end

   // side band, stages 4 .. 41
   side_type side_ff [SIDE_N];

   always_ff @(posedge clock) begin
      side_ff[0] <= '{pt: pt3_ff, nz: nz3_ff};
      for (int k = 1; k < SIDE_N; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // stages 4 .. 19: square roots
   logic [15:0] r_w, rho_w;

   svi_isqrt u_sqrt_r (
      .clock (clock),
      .val   (s3_ff),
      .root  (r_w)
   );

   svi_isqrt u_sqrt_rho (
      .clock (clock),
      .val   (sxy_ff),
      .root  (rho_w)
   );

   // stages 20 .. 39: angles
   logic [15:0]                        absx_w;
   logic signed [svi_pkg::ANGLE_W-1:0] acc_t_w, acc_p_w;

   assign absx_w = side_ff[TAP19].pt.x[15] ? 16'(-side_ff[TAP19].pt.x)
                                           : 16'(side_ff[TAP19].pt.x);

   svi_cordic u_cordic_theta (
      .clock (clock),
      .x_in  (rho_w),
      .y_in  (side_ff[TAP19].pt.z),
      .angle (acc_t_w)
   );

   svi_cordic u_cordic_phi (
      .clock (clock),
      .x_in  (absx_w),
      .y_in  (side_ff[TAP19].pt.y),
      .angle (acc_p_w)
   );

   // range delay, stages 20 .. 39
   logic [15:0] rd_ff [RD_N];

   always_ff @(posedge clock) begin
      rd_ff[0] <= r_w;
      for (int k = 1; k < RD_N; k++) begin
         rd_ff[k] <= rd_ff[k-1];
      end
   end

   // stage 20: normalize range for log2
   logic [3:0]  msb_in;
   logic [30:0] m0_in;
   logic [3:0]  nmsb_ff;
   logic [30:0] nm_ff;

   always_comb begin
      msb_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (r_w[i]) begin
            msb_in = 4'(i);
         end
      end
      m0_in = 31'({r_w, 15'h0000} << (4'd15 - msb_in));
   end

   always_ff @(posedge clock) begin
      nm_ff   <= m0_in;
      nmsb_ff <= msb_in;
   end

   // stages 21 .. 36: one fraction bit per squaring
   logic [30:0] lm_ff [svi_pkg::LN_STEPS];
   logic [15:0] lf_ff [svi_pkg::LN_STEPS];
   logic [3:0]  le_ff [svi_pkg::LN_STEPS];

   for (genvar i = 0; i < svi_pkg::LN_STEPS; i++) begin : g_ln
      logic [30:0] m_prev;
      logic [15:0] f_prev;
      logic [3:0]  e_prev;
      logic [61:0] sq;
      logic [31:0] t;

      if (i == 0) begin : g_first
         assign m_prev = nm_ff;
         assign f_prev = '0;
         assign e_prev = nmsb_ff;
      end else begin : g_next
         assign m_prev = lm_ff[i-1];
         assign f_prev = lf_ff[i-1];
         assign e_prev = le_ff[i-1];
      end

      assign sq = m_prev * m_prev;
      assign t  = sq[61:30];

      always_ff @(posedge clock) begin
         lm_ff[i] <= t[31] ? t[31:1] : t[30:0];
         lf_ff[i] <= {f_prev[14:0], t[31]};
         le_ff[i] <= e_prev;
      end
   end

   // stages 37 .. 39: scale log2 to ln, round
   logic signed [4:0]  le_in;
   logic signed [20:0] l2_in;
   logic signed [37:0] lp_in, lp_ff;
   logic signed [17:0] ln_ff, ln2_ff;

   assign le_in = $signed({1'b0, le_ff[svi_pkg::LN_STEPS-1]}) - 5'sd8;
   assign l2_in = {le_in, lf_ff[svi_pkg::LN_STEPS-1]};
   assign lp_in = l2_in * 38'(svi_pkg::LN2_Q16);

   always_ff @(posedge clock) begin
      lp_ff  <= lp_in;
      ln_ff  <= 18'((lp_ff + 38'sd524288) >>> 20);
      ln2_ff <= ln_ff;
   end

   // stage 40: Q14 angles, depth quantity
   logic signed [24:0] td_in, pd_in;
   logic signed [17:0] thq_ff, phq_ff, dq_ff;

   assign td_in = 25'(svi_pkg::HALF_PI_Q20) - 25'(acc_t_w) + 25'sd32;
   assign pd_in = 25'(acc_p_w) + 25'sd32;

   always_ff @(posedge clock) begin
      thq_ff <= 18'(td_in >>> 6);
      phq_ff <= 18'(pd_in >>> 6);
      dq_ff  <= log_depth_ff ? ln2_ff : $signed({2'b00, rd_ff[RD_N-1]});
   end

   // stage 41: bin products
   logic signed [34:0] prow_in, pcol_in, pdep_in;
   logic signed [34:0] prow_ff, pcol_ff, pdep_ff;

   assign prow_in = thq_ff * $signed({1'b0, inv_theta_ff});
   assign pcol_in = phq_ff * $signed({1'b0, inv_phi_ff});
   assign pdep_in = dq_ff * $signed({1'b0, inv_depth_ff});

   always_ff @(posedge clock) begin
      prow_ff <= prow_in;
      pcol_ff <= pcol_in;
      pdep_ff <= pdep_in;
   end

   // stage 42: truncate, range check, output
   logic [ROW_CW-1:0] row_lim;
   logic [COL_CW-1:0] col_lim;
   logic [DEP_CW-1:0] dep_lim;
   logic [19:0]       brow, bcol, bdep;
   logic [4:0]        dep_sh;
   logic              ok_in;

   function automatic logic [19:0] bin_of(input logic signed [34:0] p,
                                          input logic [4:0] sh,
                                          input logic [19:0] lim);
      logic [34:0] mag;
      logic [18:0] idx;
      logic        ok;
      mag = p[34] ? 35'(-p) : 35'(p);
      idx = 19'(mag >> sh);
      ok  = !(p[34] && idx != '0) && ({1'b0, idx} < lim);
      return {ok, idx};
   endfunction

   always_comb begin
      row_lim = (int'(row_cnt_ff) > MAX_ROWS) ? ROW_CW'(MAX_ROWS) : ROW_CW'(row_cnt_ff);
      col_lim = (int'(col_cnt_ff) > MAX_COLUMNS) ? COL_CW'(MAX_COLUMNS)
                                                 : COL_CW'(col_cnt_ff);
      dep_lim = (int'(dep_cnt_ff) > MAX_DEPTHS) ? DEP_CW'(MAX_DEPTHS) : DEP_CW'(dep_cnt_ff);
      dep_sh  = log_depth_ff ? 5'(svi_pkg::LOG_SHIFT) : 5'(svi_pkg::LIN_SHIFT);
      brow    = bin_of(prow_ff, 5'(svi_pkg::ANGLE_SHIFT), 20'(row_lim));
      bcol    = bin_of(pcol_ff, 5'(svi_pkg::ANGLE_SHIFT), 20'(col_lim));
      bdep    = bin_of(pdep_ff, dep_sh, 20'(dep_lim));
      ok_in   = side_ff[SIDE_N-1].nz && brow[19] && bcol[19] && bdep[19];
   end

   always_ff @(posedge clock) begin
      rsp_valid_res    <= ok_in;
      rsp_row_index    <= ok_in ? brow[9:0] : 10'd0;
      rsp_column_index <= ok_in ? bcol[9:0] : 10'd0;
      rsp_depth_index  <= ok_in ? bdep[9:0] : 10'd0;
      rsp_x_out        <= side_ff[SIDE_N-1].pt.x;
      rsp_y_out        <= side_ff[SIDE_N-1].pt.y;
      rsp_z_out        <= side_ff[SIDE_N-1].pt.z;
      rsp_refl_out     <= side_ff[SIDE_N-1].pt.refl;
   end

   assign rsp_valid = vld_ff[LAT];

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the spherical point voxel indexer.
module testbench;

   localparam logic [svi_pkg::CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT  = 4000;

   typedef struct packed {
      logic              ok;
      logic [9:0]        row;
      logic [9:0]        col;
      logic [9:0]        dep;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [15:0]       refl;
   } voxel_type;

   class voxel_scoreboard;
      voxel_type pending_voxels[$];
      longint    theta_step, phi_step, depth_step;
      longint    rows, cols, deps;
      bit        use_log;
      int        mismatches;
      int        unexpected;

      function void reset_regs();
         theta_step = 256; phi_step = 256; depth_step = 256;
         rows = 1024; cols = 1024; deps = 1024; use_log = 0;
      endfunction

      function void write_reg(logic [svi_pkg::CSR_ADDR_W-1:0] idx, logic [15:0] data);
         case (idx)
            svi_pkg::REG_INV_THETA:  theta_step = data;
            svi_pkg::REG_INV_PHI:    phi_step = data;
            svi_pkg::REG_INV_DEPTH:  depth_step = data;
            svi_pkg::REG_ROW_CNT:    rows = data[10:0];
            svi_pkg::REG_COLUMN_CNT: cols = data[10:0];
            svi_pkg::REG_DEPTH_CNT:  deps = data[10:0];
            svi_pkg::REG_LOG_DEPTH:  use_log = data[0];
            default: ;
         endcase
      endfunction

      function longint root(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 34;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return longint'(res);
      endfunction

      // vectoring rotation, angle in 2^-20 rad
      function longint vector_angle(longint yv, longint xv);
         longint a, b, acc, da, db;
         a = xv * 256;
         b = yv * 256;
         acc = 0;
         for (int i = 0; i < svi_pkg::CORDIC_STEPS; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
               a += da; b -= db; acc += svi_pkg::ATAN_Q20[i];
            end else begin
               a -= da; b += db; acc -= svi_pkg::ATAN_Q20[i];
            end
         end
         return acc;
      endfunction

      function longint log_range(longint unsigned rv);
         int unsigned msb;
         longint unsigned m;
         longint frac, l2;
         msb = 0;
         frac = 0;
         while (msb < 40 && (rv >> (msb + 1)) != 0) msb++;
         m = rv << (30 - msb);
         for (int i = 0; i < svi_pkg::LN_STEPS; i++) begin
            m = (m * m) >> 30;
            frac <<= 1;
            if (m >= (64'd2 << 30)) begin
               m >>= 1;
               frac |= 1;
            end
         end
         l2 = longint'(msb) * 65536 + frac - 8 * 65536;
         return (l2 * svi_pkg::LN2_Q16 + (64'sd1 <<< 19)) >>> 20;
      endfunction

      function longint bin_of(longint v, int s);
         if (v >= 0) return v >>> s;
         return -((-v) >>> s);
      endfunction

      function longint bound(longint c, longint lim);
         return c > lim ? lim : c;
      endfunction

      function void note(svi_pkg::point_type p);
         voxel_type e;
         longint x, y, z, x2y2, r, rho, theta, phi, ri, ci, di;
         x = p.x; y = p.y; z = p.z;
         x2y2 = x * x + y * y;
         ri = 0; ci = 0; di = 0;
         e.ok = 0;
         if (x2y2 != 0) begin
            r = root(x2y2 + z * z);
            rho = root(x2y2);
            theta = (svi_pkg::HALF_PI_Q20 - vector_angle(z, rho) + 32) >>> 6;
            phi = (vector_angle(y, x < 0 ? -x : x) + 32) >>> 6;
            ri = bin_of(theta * theta_step, svi_pkg::ANGLE_SHIFT);
            ci = bin_of(phi * phi_step, svi_pkg::ANGLE_SHIFT);
            if (use_log) di = bin_of(log_range(r) * depth_step, svi_pkg::LOG_SHIFT);
            else di = bin_of(r * depth_step, svi_pkg::LIN_SHIFT);
            e.ok = ri >= 0 && ri < bound(rows, 1024) && ci >= 0 && ci < bound(cols, 1024)
                   && di >= 0 && di < bound(deps, 1024);
         end
         if (!e.ok) begin
            ri = 0; ci = 0; di = 0;
         end
         e.row = ri[9:0]; e.col = ci[9:0]; e.dep = di[9:0];
         e.x = p.x; e.y = p.y; e.z = p.z; e.refl = p.refl;
         pending_voxels = {pending_voxels, e};
      endfunction

      function void check(voxel_type got);
         voxel_type e;
         if (pending_voxels.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10) $display("unexpected result at %0t", $time);
            return;
         end
         e = pending_voxels.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
               $display("mismatch at %0t: exp ok=%0d r=%0d c=%0d d=%0d xyz=%0d,%0d,%0d rf=%0d",
                        $time, e.ok, e.row, e.col, e.dep, e.x, e.y, e.z, e.refl);
               $display("              got ok=%0d r=%0d c=%0d d=%0d xyz=%0d,%0d,%0d rf=%0d",
                        got.ok, got.row, got.col, got.dep, got.x, got.y, got.z, got.refl);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_x_pos = 0, req_y_pos = 0, req_z_pos = 0;
   logic [15:0] req_reflectance = 0;
   logic rsp_valid, rsp_valid_res;
   logic [9:0] rsp_row_index, rsp_column_index, rsp_depth_index;
   logic signed [15:0] rsp_x_out, rsp_y_out, rsp_z_out;
   logic [15:0] rsp_refl_out;
   logic csr_valid = 0;
   logic csr_ready;
   logic [svi_pkg::CSR_ADDR_W-1:0] csr_index = '0;
   logic [svi_pkg::CSR_DATA_W-1:0] csr_data = '0;

   voxel_scoreboard voxels = new();
   int idle_pct = 0;
   int stall_count = 0;

   always #6 clock = ~clock;

   spherical_point_voxel_indexer i_dut (.*);

   always @(posedge clock) begin
      voxel_type got;
      if (!reset && rsp_valid) begin
         got.ok = rsp_valid_res; got.row = rsp_row_index; got.col = rsp_column_index;
         got.dep = rsp_depth_index; got.x = rsp_x_out; got.y = rsp_y_out;
         got.z = rsp_z_out; got.refl = rsp_refl_out;
         voxels.check(got);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] rf);
      svi_pkg::point_type p;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_x_pos <= x; req_y_pos <= y; req_z_pos <= z; req_reflectance <= rf;
      @(posedge clock);
      while (busy) @(posedge clock);
      p.x = x; p.y = y; p.z = z; p.refl = rf;
      voxels.note(p);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (voxels.pending_voxels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [svi_pkg::CSR_ADDR_W-1:0] idx, logic [15:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      voxels.write_reg(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_step();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'($urandom);
         default: return 16'($urandom_range(64, 4096));
      endcase
   endfunction

   function automatic logic [15:0] pick_count();
      case ($urandom_range(6))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd2047;
         3: return 16'($urandom);
         default: return 16'd1024;
      endcase
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 15)) - 16'd8;
         2: return 16'($urandom_range(0, 4095)) - 16'd2048;
         default: return 16'($urandom_range(0, 32767)) - 16'd16384;
      endcase
   endfunction

   task automatic random_block(int n);
      logic [15:0] x, y;
      for (int i = 0; i < n; i++) begin
         x = pick_coord();
         y = pick_coord();
         if ($urandom_range(19) == 0) begin
            x = 0;
            y = 0;
         end
         send_point(x, y, pick_coord(), 16'($urandom));
      end
   endtask

   initial begin
      voxels.reset_regs();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_point(0, 0, 0, 16'hffff);
      send_point(0, 0, 16'h7fff, 0);
      send_point(0, 0, 16'h8000, 16'h1234);
      send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
      send_point(16'h8000, 16'h8000, 16'h8000, 0);
      send_point(16'h8000, 0, 0, 16'h5555);
      send_point(16'h7fff, 16'h8000, 16'h0100, 16'haaaa);
      send_point(1, 0, 0, 1);
      send_point(16'hffff, 1, 16'hffff, 2);
      send_point(0, 16'h0100, 16'hff00, 3);
      send_point(0, 16'hff00, 16'h0100, 4);
      send_point(16'h0a00, 16'hf600, 0, 5);
      drain();

      write_csr(svi_pkg::REG_LOG_DEPTH, 16'd1);
      write_csr(svi_pkg::REG_INV_DEPTH, 16'hffff);
      write_csr(svi_pkg::REG_INV_THETA, 16'hffff);
      write_csr(svi_pkg::REG_INV_PHI, 16'd0);
      write_csr(svi_pkg::REG_ROW_CNT, 16'd2047);
      write_csr(svi_pkg::REG_COLUMN_CNT, 16'd1);
      write_csr(svi_pkg::REG_DEPTH_CNT, 16'd0);
      write_csr(REG_UNUSED, 16'hffff);
      send_point(1, 0, 0, 6);
      send_point(16'h0100, 0, 0, 7);
      send_point(16'h7fff, 16'h7fff, 16'h7fff, 8);
      drain();
      write_csr(svi_pkg::REG_DEPTH_CNT, 16'd1024);
      send_point(16'h0100, 0, 0, 9);
      send_point(16'h0200, 16'h0300, 16'h8000, 10);
      send_point(16'hff00, 16'h8000, 16'h7fff, 11);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = phase == 0 ? 7 : (phase == 1 ? 87 : 0);
         for (int blk = 0; blk < 4; blk++) begin
            drain();
            write_csr(svi_pkg::REG_INV_THETA, pick_step());
            write_csr(svi_pkg::REG_INV_PHI, pick_step());
            write_csr(svi_pkg::REG_INV_DEPTH, pick_step());
            write_csr(svi_pkg::REG_ROW_CNT, pick_count());
            write_csr(svi_pkg::REG_COLUMN_CNT, pick_count());
            write_csr(svi_pkg::REG_DEPTH_CNT, pick_count());
            write_csr(svi_pkg::REG_LOG_DEPTH, 16'($urandom_range(1)));
            random_block(57);
         end
      end

      start <= 0;
      @(posedge clock);
      while (voxels.pending_voxels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (voxels.mismatches == 0 && voxels.unexpected == 0
          && voxels.pending_voxels.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
